[rtl/twcs_pkg.sv]
`timescale 1ns / 1ps
package twcs_pkg;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_HEIGHT = 2'd2;

   localparam logic [12:0] DISPLAY_WIDTH_RESET  = 13'd512;
   localparam logic [6:0]  TEXTURE_WIDTH_RESET  = 7'd64;
   localparam logic [6:0]  TEXTURE_HEIGHT_RESET = 7'd64;

   localparam logic [1:0] COL_DIV   = 2'd0;
   localparam logic [1:0] COL_FIRST = 2'd1;
   localparam logic [1:0] COL_LAST  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic               operation;
      logic [3:0]         texture_number;
      logic [11:0]        texel_index;
      logic [23:0]        texel_color;
      logic [11:0]        screen_x;
      logic [11:0]        screen_y;
      logic signed [15:0] wall_bottom;
      logic signed [15:0] wall_top;
      logic [15:0]        hit_fraction;
      logic [7:0]         shade;
      logic               skip_column;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_address;
      logic [23:0] pixel_color;
   } rsp_type;

   typedef struct packed {
      logic [12:0] display_width;
      logic [6:0]  texture_width;
      logic [6:0]  texture_height;
   } cfg_type;

   typedef struct packed {
      logic        is_load;
      logic        tex_ok;
      logic [3:0]  texture_number;
      logic [11:0] texel_index;
      logic [23:0] texel_color;
      logic [11:0] screen_x;
      logic [11:0] screen_y;
      logic [15:0] offset;
      logic [15:0] span;
      logic [1:0]  col_mode;
      logic [15:0] hit_fraction;
      logic [7:0]  shade;
   } work_type;

   // exact p / 255 for p up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] t;
      t = 17'(p) + 17'(p[15:8]) + 17'd1;
      return t[15:8];
   endfunction

endpackage

[rtl/twcs_ram.sv]
`timescale 1ns / 1ps
module twcs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/twcs_front.sv]
`timescale 1ns / 1ps
module twcs_front import twcs_pkg::*; #(
   parameter int TEXTURE_COUNT    = 16,
   parameter int TEXTURE_SIDE_MAX = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req,
   output logic     work_valid,
   output work_type work
);

   localparam int AREA = TEXTURE_SIDE_MAX * TEXTURE_SIDE_MAX;

   logic signed [16:0] span_s;
   logic signed [16:0] offset_s;
   logic               tex_ok;
   logic               idx_ok;
   logic               keep;
   logic               push;
   logic               pop;
   work_type           entry;

   work_type                 q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   // classify
   always_comb begin
      span_s   = {req.wall_top[15], req.wall_top} - {req.wall_bottom[15], req.wall_bottom};
      offset_s = {5'd0, req.screen_x} - {req.wall_bottom[15], req.wall_bottom};
      tex_ok   = 32'(req.texture_number) < TEXTURE_COUNT;
      idx_ok   = 32'(req.texel_index) < AREA;
      if (req.operation == OP_LOAD) begin
         keep = tex_ok & idx_ok;
      end else begin
         keep = !req.skip_column & !span_s[16] & (span_s != 17'sd0);
      end

      entry.is_load        = req.operation == OP_LOAD;
      entry.tex_ok         = tex_ok;
      entry.texture_number = req.texture_number;
      entry.texel_index    = req.texel_index;
      entry.texel_color    = req.texel_color;
      entry.screen_x       = req.screen_x;
      entry.screen_y       = req.screen_y;
      entry.offset         = offset_s[15:0];
      entry.span           = span_s[15:0];
      entry.hit_fraction   = req.hit_fraction;
      entry.shade          = req.shade;
      priority if (offset_s[16]) begin
         entry.col_mode = COL_FIRST;
      end else if (offset_s >= span_s) begin
         entry.col_mode = COL_LAST;
      end else begin
         entry.col_mode = COL_DIV;
      end
   end

   // decoupling queue
   assign busy = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign push = start & !busy & keep;
   assign pop  = count_ff != '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry;
      end
   end

   assign work_valid = pop;
   assign work       = q_mem_ff[rd_ptr_ff];

endmodule

[rtl/twcs_back.sv]
`timescale 1ns / 1ps
module twcs_back import twcs_pkg::*; #(
   parameter int TEXTURE_COUNT    = 16,
   parameter int TEXTURE_SIDE_MAX = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     work_valid,
   input  work_type work,
   output logic     rsp_valid,
   output rsp_type  rsp
);

   localparam int SW    = $clog2(TEXTURE_SIDE_MAX + 1);
   localparam int QW    = $clog2(TEXTURE_SIDE_MAX);
   localparam int AREA  = TEXTURE_SIDE_MAX * TEXTURE_SIDE_MAX;
   localparam int SLW   = $clog2(AREA);
   localparam int DEPTH = TEXTURE_COUNT * AREA;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = SW + 16;
   localparam int RW    = QW + 17;
   localparam int MW    = QW + SW;

   typedef struct packed {
      logic          is_load;
      logic          tex_ok;
      logic [3:0]    texture_number;
      logic [11:0]   texel_index;
      logic [23:0]   texel_color;
      logic [11:0]   screen_x;
      logic [1:0]    col_mode;
      logic [QW-1:0] row;
      logic [7:0]    shade;
      logic [24:0]   pitch;
   } carry_type;

   function automatic logic [SW-1:0] clamp_side(input logic [6:0] v);
      if (v == 7'd0) begin
         return SW'(1);
      end else if (32'(v) > TEXTURE_SIDE_MAX) begin
         return SW'(TEXTURE_SIDE_MAX);
      end else begin
         return SW'(v);
      end
   endfunction

   logic [SW-1:0] tex_w;
   logic [SW-1:0] tex_h;

   assign tex_w = clamp_side(cfg.texture_width);
   assign tex_h = clamp_side(cfg.texture_height);

   // multiply stage
   logic [PW-1:0] col_prod;
   logic [PW-1:0] row_prod;
   carry_type     m_c_in, m_c_ff;
   logic [RW-1:0] m_rem_in, m_rem_ff;
   logic [15:0]   m_span_ff;
   logic          m_valid_ff;

   always_comb begin
      col_prod              = PW'(tex_w) * PW'(work.offset);
      row_prod              = PW'(tex_h) * PW'(work.hit_fraction);
      m_rem_in              = RW'(col_prod);
      m_c_in.is_load        = work.is_load;
      m_c_in.tex_ok         = work.tex_ok;
      m_c_in.texture_number = work.texture_number;
      m_c_in.texel_index    = work.texel_index;
      m_c_in.texel_color    = work.texel_color;
      m_c_in.screen_x       = work.screen_x;
      m_c_in.col_mode       = work.col_mode;
      m_c_in.row            = QW'(row_prod[PW-1:16]);
      m_c_in.shade          = work.shade;
      m_c_in.pitch          = 25'(cfg.display_width) * 25'(work.screen_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= work_valid;
      end
   end

   always_ff @(posedge clock) begin
      m_c_ff    <= m_c_in;
      m_rem_ff  <= m_rem_in;
      m_span_ff <= work.span;
   end

   // restoring divider, one quotient bit per stage
   logic          dv_valid_ff [QW];
   logic [RW-1:0] dv_rem_ff   [QW];
   logic [QW-1:0] dv_q_ff     [QW];
   logic [15:0]   dv_span_ff  [QW];
   carry_type     dv_c_ff     [QW];

   for (genvar i = 0; i < QW; i++) begin : g_div
      localparam int B = QW - 1 - i;
      logic          prev_valid;
      logic [RW-1:0] prev_rem;
      logic [QW-1:0] prev_q;
      logic [15:0]   prev_span;
      carry_type     prev_c;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] q_in;

      if (i == 0) begin : g_first
         assign prev_valid = m_valid_ff;
         assign prev_rem   = m_rem_ff;
         assign prev_q     = '0;
         assign prev_span  = m_span_ff;
         assign prev_c     = m_c_ff;
      end else begin : g_next
         assign prev_valid = dv_valid_ff[i-1];
         assign prev_rem   = dv_rem_ff[i-1];
         assign prev_q     = dv_q_ff[i-1];
         assign prev_span  = dv_span_ff[i-1];
         assign prev_c     = dv_c_ff[i-1];
      end

      assign trial = RW'(prev_span) << B;

      always_comb begin
         if (prev_rem >= trial) begin
            rem_in = prev_rem - trial;
            q_in   = prev_q | (QW'(1) << B);
         end else begin
            rem_in = prev_rem;
            q_in   = prev_q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i] <= 1'b0;
         end else begin
            dv_valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         dv_rem_ff[i]  <= rem_in;
         dv_q_ff[i]    <= q_in;
         dv_span_ff[i] <= prev_span;
         dv_c_ff[i]    <= prev_c;
      end
   end

   // address stage
   carry_type      d_c;
   logic [MW-1:0]  rowtw;
   logic           a_valid_ff;
   logic           a_is_load_in, a_is_load_ff;
   logic           a_tex_ok_ff;
   logic [23:0]    a_color_ff;
   logic [AW-1:0]  a_base_in, a_base_ff;
   logic [SLW-1:0] a_slot_in, a_slot_ff;
   logic [QW-1:0]  a_col_in, a_col_ff;
   logic [23:0]    a_pix_in, a_pix_ff;
   logic [7:0]     a_shade_ff;

   assign d_c = dv_c_ff[QW-1];

   always_comb begin
      rowtw        = MW'(d_c.row) * MW'(tex_w);
      a_is_load_in = d_c.is_load;
      a_base_in    = AW'(32'(d_c.texture_number) * AREA);
      a_pix_in     = 24'(d_c.pitch + 25'(d_c.screen_x));
      unique case (d_c.col_mode)
         COL_DIV:   a_col_in = dv_q_ff[QW-1];
         COL_FIRST: a_col_in = '0;
         COL_LAST:  a_col_in = QW'(tex_w - SW'(1));
         default:   a_col_in = '0;
      endcase
      if (d_c.is_load) begin
         a_slot_in = SLW'(d_c.texel_index);
         a_col_in  = '0;
      end else begin
         a_slot_in = SLW'(rowtw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= dv_valid_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      a_is_load_ff <= a_is_load_in;
      a_tex_ok_ff  <= d_c.tex_ok;
      a_color_ff   <= d_c.texel_color;
      a_base_ff    <= a_base_in;
      a_slot_ff    <= a_slot_in;
      a_col_ff     <= a_col_in;
      a_pix_ff     <= a_pix_in;
      a_shade_ff   <= d_c.shade;
   end

   // texture store access
   logic [AW-1:0] mem_addr;
   logic          mem_wr;
   logic          mem_rd;
   logic [23:0]   texel_raw;

   assign mem_addr = a_base_ff + AW'(a_slot_ff) + AW'(a_col_ff);
   assign mem_wr   = a_valid_ff & a_is_load_ff;
   assign mem_rd   = a_valid_ff & !a_is_load_ff;

   twcs_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (a_color_ff),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (texel_raw)
   );

   logic        r_valid_ff;
   logic        r_tex_ok_ff;
   logic [23:0] r_pix_ff;
   logic [7:0]  r_shade_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= mem_rd;
      end
   end

   always_ff @(posedge clock) begin
      r_tex_ok_ff <= a_tex_ok_ff;
      r_pix_ff    <= a_pix_ff;
      r_shade_ff  <= a_shade_ff;
   end

   // shade multiply
   logic [23:0] texel;
   logic        s_valid_ff;
   logic [15:0] s_red_in, s_red_ff;
   logic [15:0] s_grn_in, s_grn_ff;
   logic [15:0] s_blu_in, s_blu_ff;
   logic [23:0] s_pix_ff;

   always_comb begin
      texel    = r_tex_ok_ff ? texel_raw : 24'd0;
      s_red_in = 16'(texel[23:16]) * 16'(r_shade_ff);
      s_grn_in = 16'(texel[15:8])  * 16'(r_shade_ff);
      s_blu_in = 16'(texel[7:0])   * 16'(r_shade_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_red_ff <= s_red_in;
      s_grn_ff <= s_grn_in;
      s_blu_ff <= s_blu_in;
      s_pix_ff <= r_pix_ff;
   end

   // output word
   logic    rsp_valid_ff;
   rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.pixel_address = s_pix_ff;
      rsp_in.pixel_color   = {div255(s_red_ff), div255(s_grn_ff), div255(s_blu_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/textured_wall_column_shader_core.sv]
`timescale 1ns / 1ps
// result: each accepted draw word gives one result; loads and dropped words give no result
// throughput: one word per cycle, set by the divider with one quotient bit per stage
// and the texture RAM with registered read; the result port cannot stall
// reset: synchronous, clears the pipeline, the queue and the registers to 512/64/64;
// texture RAM contents are not cleared and read as undefined until loaded
module textured_wall_column_shader_core import twcs_pkg::*; #(
   parameter int TEXTURE_COUNT    = 16,
   parameter int TEXTURE_SIDE_MAX = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_word,
   output logic                   rsp_valid,
   output rsp_type                rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg_in, cfg_ff;
   logic     work_valid;
   work_type work;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DISPLAY_WIDTH:  cfg_in.display_width  = csr_data;
            CSR_TEXTURE_WIDTH:  cfg_in.texture_width  = csr_data[6:0];
            CSR_TEXTURE_HEIGHT: cfg_in.texture_height = csr_data[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_width  <= DISPLAY_WIDTH_RESET;
         cfg_ff.texture_width  <= TEXTURE_WIDTH_RESET;
         cfg_ff.texture_height <= TEXTURE_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   twcs_front #(
      .TEXTURE_COUNT    (TEXTURE_COUNT),
      .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req        (req_word),
      .work_valid (work_valid),
      .work       (work)
   );

   twcs_back #(
      .TEXTURE_COUNT    (TEXTURE_COUNT),
      .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_valid (work_valid),
      .work       (work),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_word)
   );

endmodule

[rtl/twcs_checker.sv]
`timescale 1ns / 1ps
module twcs_checker import twcs_pkg::*; #(
   parameter int TEXTURE_SIDE_MAX = 64
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_word,
   input logic    rsp_valid,
   input rsp_type rsp_word
);

   localparam int LAT = $clog2(TEXTURE_SIDE_MAX) + 6;

   logic draw_taken;

   assign draw_taken = start && !busy && req_word.operation == OP_DRAW
                       && !req_word.skip_column;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("result or busy after reset");

   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(draw_taken, LAT))
      else $error("result without a drawn word at fixed latency");

   a_span_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_word.wall_top, LAT) > $past(req_word.wall_bottom, LAT))
      else $error("result from an empty span");

   a_dark_shade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_word.shade, LAT) == 8'd0 |-> rsp_word.pixel_color == 24'd0)
      else $error("zero shade gave a lit pixel");

endmodule

bind textured_wall_column_shader_core twcs_checker #(
   .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);
